// ----- sv/acf_pkg.sv -----
// ---------------------------------------------------------------------------
// Altitude complementary filter package
// Widths, control word layout, microcode program and saturation helper shared
// by the sequencer, the datapath and the top level.
// ---------------------------------------------------------------------------
package acf_pkg;

	// Field widths
	localparam int SAMPLE_W = 32;
	localparam int DT_W     = 16;
	localparam int ALPHA_W  = 16;
	localparam int HZ_W     = 10;
	localparam int CFG_W    = 16;
	localparam int TEMP_W   = 25;	// weight * rate, at most 32768 * 1023
	localparam int MA_W     = 33;	// multiplier operand A, signed
	localparam int MB_W     = TEMP_W + 1;	// multiplier operand B, signed
	localparam int PROD_W   = MA_W + MB_W;
	localparam int ACC_W    = 62;
	localparam int ADDR_W   = 4;

	localparam logic [ALPHA_W-1:0] ONE_Q15        = 16'd32768;
	localparam logic [ALPHA_W-1:0] BLEND_RESET    = 16'd32113;
	localparam logic [HZ_W-1:0]    BARO_HZ_RESET  = 10'd100;
	localparam logic signed [31:0] S32_MAX        = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN        = 32'sh8000_0000;

	// Configuration register indexes
	typedef enum logic {
		REG_BLEND_WEIGHT = 1'b0,
		REG_BARO_RATE    = 1'b1
	} reg_idx_t;

	// Item kinds
	localparam logic KIND_BARO  = 1'b0;
	localparam logic KIND_ACCEL = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	// Program entry points
	localparam addr_t ADDR_BARO     = 4'd0;
	localparam addr_t ADDR_ACCEL    = 4'd7;
	localparam addr_t ADDR_INIT     = 4'd13;
	localparam addr_t ADDR_DISPATCH = 4'd14;
	localparam addr_t ADDR_FIN      = 4'd15;

	typedef enum logic [2:0] {
		MA_ALT  = 3'd0,
		MA_RATE = 3'd1,
		MA_REL  = 3'd2,
		MA_DIFF = 3'd3,
		MA_SMP  = 3'd4,
		MA_HZ   = 3'd5
	} mula_t;

	typedef enum logic [1:0] {
		MB_ALPHA  = 2'd0,
		MB_WEIGHT = 2'd1,
		MB_TEMP   = 2'd2,
		MB_DT     = 2'd3
	} mulb_t;

	typedef enum logic [2:0] {
		ACC_HOLD   = 3'd0,
		ACC_PROD   = 3'd1,
		ACC_ADD    = 3'd2,
		ACC_RATE16 = 3'd3,
		ACC_ALT16  = 3'd4
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE   = 3'd0,
		WB_TEMP   = 3'd1,
		WB_ALT15  = 3'd2,
		WB_RATE15 = 3'd3,
		WB_ALT16  = 3'd4,
		WB_RATE16 = 3'd5,
		WB_INIT   = 3'd6
	} wb_t;

	typedef enum logic {
		J_NEXT     = 1'b0,
		J_DISPATCH = 1'b1
	} jump_t;

	// One control word of the program
	typedef struct packed {
		mula_t   mul_a;
		mulb_t   mul_b;
		acc_op_t acc_op;
		wb_t     wb;
		jump_t   jump;
		logic    fin;
		addr_t   next;
	} ctl_t;

	// Status the datapath reports for the dispatch jump
	typedef struct packed {
		logic kind;
		logic started;
		logic dt_zero;
	} acf_status_t;

	function automatic ctl_t uword(input mula_t a, input mulb_t b, input acc_op_t op,
			input wb_t wb, input jump_t j, input logic fin, input addr_t nxt);
		ctl_t w;
		w.mul_a  = a;
		w.mul_b  = b;
		w.acc_op = op;
		w.wb     = wb;
		w.jump   = j;
		w.fin    = fin;
		w.next   = nxt;
		return w;
	endfunction

	// Microcode program. The product register is loaded in every step and is
	// consumed by the accumulator one step later.
	function automatic ctl_t ucode_rom(input addr_t pc);
		ctl_t w;
		case (pc)
			// Barometer blend: temp = hz * (1 - alpha), then both blends
			4'd0:  w = uword(MA_HZ,   MB_WEIGHT, ACC_HOLD,   WB_NONE,   J_NEXT, 1'b0, 4'd1);
			4'd1:  w = uword(MA_ALT,  MB_ALPHA,  ACC_HOLD,   WB_TEMP,   J_NEXT, 1'b0, 4'd2);
			4'd2:  w = uword(MA_REL,  MB_WEIGHT, ACC_PROD,   WB_NONE,   J_NEXT, 1'b0, 4'd3);
			4'd3:  w = uword(MA_RATE, MB_ALPHA,  ACC_ADD,    WB_NONE,   J_NEXT, 1'b0, 4'd4);
			4'd4:  w = uword(MA_DIFF, MB_TEMP,   ACC_PROD,   WB_ALT15,  J_NEXT, 1'b0, 4'd5);
			4'd5:  w = uword(MA_DIFF, MB_TEMP,   ACC_ADD,    WB_NONE,   J_NEXT, 1'b0, 4'd6);
			4'd6:  w = uword(MA_DIFF, MB_TEMP,   ACC_HOLD,   WB_RATE15, J_NEXT, 1'b0, ADDR_FIN);
			// Acceleration: integrate climb rate, then altitude
			4'd7:  w = uword(MA_SMP,  MB_DT,     ACC_HOLD,   WB_NONE,   J_NEXT, 1'b0, 4'd8);
			4'd8:  w = uword(MA_SMP,  MB_DT,     ACC_RATE16, WB_NONE,   J_NEXT, 1'b0, 4'd9);
			4'd9:  w = uword(MA_SMP,  MB_DT,     ACC_HOLD,   WB_RATE16, J_NEXT, 1'b0, 4'd10);
			4'd10: w = uword(MA_RATE, MB_DT,     ACC_HOLD,   WB_NONE,   J_NEXT, 1'b0, 4'd11);
			4'd11: w = uword(MA_RATE, MB_DT,     ACC_ALT16,  WB_NONE,   J_NEXT, 1'b0, 4'd12);
			4'd12: w = uword(MA_RATE, MB_DT,     ACC_HOLD,   WB_ALT16,  J_NEXT, 1'b0, ADDR_FIN);
			// First barometer sample
			4'd13: w = uword(MA_ALT,  MB_ALPHA,  ACC_HOLD,   WB_INIT,   J_NEXT, 1'b0, ADDR_FIN);
			// Dispatch on the item kind and the filter status
			4'd14: w = uword(MA_ALT,  MB_ALPHA,  ACC_HOLD,   WB_NONE,   J_DISPATCH, 1'b0,
					ADDR_FIN);
			default: w = uword(MA_ALT, MB_ALPHA, ACC_HOLD,   WB_NONE,   J_NEXT, 1'b1, ADDR_FIN);
		endcase
		return w;
	endfunction

	// Saturate an accumulator value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[ACC_W-1:31];
		all_zeros = ~|v[ACC_W-1:31];
		if (all_ones || all_zeros) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return S32_MIN;
		end else begin
			return S32_MAX;
		end
	endfunction

endpackage

// ----- sv/acf_if.sv -----
// ---------------------------------------------------------------------------
// Altitude complementary filter channel interfaces
// Valid/ready channels for sensor items, filter results and register writes.
// ---------------------------------------------------------------------------

// Sensor item channel
interface acf_item_if import acf_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic signed [SAMPLE_W-1:0]  sample;
	logic        [DT_W-1:0]      step_time;

	modport source (output valid, kind, sample, step_time, input ready);
	modport sink   (input valid, kind, sample, step_time, output ready);
endinterface

// Filter result channel
interface acf_result_if import acf_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_W-1:0]  altitude;
	logic signed [SAMPLE_W-1:0]  vert_speed;
	logic                        ready_res;

	modport source (output valid, altitude, vert_speed, ready_res, input ready);
	modport sink   (input valid, altitude, vert_speed, ready_res, output ready);
endinterface

// Register write channel
interface acf_cfg_if import acf_pkg::*;;
	logic              valid;
	logic              ready;
	logic              index;
	logic [CFG_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/altitude_complementary_filter.sv -----
// ---------------------------------------------------------------------------
// Altitude complementary filter
// Each accepted item runs the dispatch step, then the barometer blend, the
// acceleration step or the first barometer sample, then the final step; an
// ignored acceleration item goes straight to the final step. A new item is
// accepted only once the last result is registered, so the shared multiplier,
// used once per microcode step, serves one item. Reset clears the estimates,
// the start flag and the registers to their reset values; no clearing pass.
// ---------------------------------------------------------------------------
module altitude_complementary_filter import acf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	acf_item_if.sink      item,
	acf_result_if.source  result,
	acf_cfg_if.sink       cfg
);

	logic [ALPHA_W-1:0] blend_weight_q;
	logic [HZ_W-1:0]    baro_rate_q;
	logic [ALPHA_W-1:0] alpha;

	ctl_t        ctl;
	acf_status_t status;
	logic        step_en;
	logic        item_ready;
	logic        load_result;
	logic        item_fire;
	logic        res_busy;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_alt_q;
	logic signed [SAMPLE_W-1:0] out_rate_q;
	logic                       out_started_q;
	logic signed [SAMPLE_W-1:0] est_alt;
	logic signed [SAMPLE_W-1:0] est_rate;

	assign item.ready = item_ready;
	assign item_fire  = item.valid && item_ready;
	assign res_busy   = out_valid_q && !result.ready;
	assign cfg.ready  = 1'b1;

	// Alpha above one is used as one
	assign alpha = (blend_weight_q > ONE_Q15) ? ONE_Q15 : blend_weight_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q <= BLEND_RESET;
			baro_rate_q    <= BARO_HZ_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_BLEND_WEIGHT: blend_weight_q <= cfg.data;
				REG_BARO_RATE:    baro_rate_q    <= cfg.data[HZ_W-1:0];
				default: ;
			endcase
		end
	end

	acf_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_fire   (item_fire),
		.status      (status),
		.res_busy    (res_busy),
		.ctl         (ctl),
		.step_en     (step_en),
		.item_ready  (item_ready),
		.load_result (load_result)
	);

	acf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_fire  (item_fire),
		.kind       (item.kind),
		.sample     (item.sample),
		.step_time  (item.step_time),
		.alpha      (alpha),
		.baro_hz    (baro_rate_q),
		.ctl        (ctl),
		.step_en    (step_en),
		.status     (status),
		.altitude   (est_alt),
		.vert_speed (est_rate)
	);

	// Result register: holds a finished transaction until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			out_alt_q     <= est_alt;
			out_rate_q    <= est_rate;
			out_started_q <= status.started;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.altitude   = out_alt_q;
	assign result.vert_speed = out_rate_q;
	assign result.ready_res  = out_started_q;

endmodule

// ----- sv/acf_sequencer.sv -----
// ---------------------------------------------------------------------------
// Altitude complementary filter sequencer
// Step counter over the microcode program, dispatch jump and handshake control.
// ---------------------------------------------------------------------------
module acf_sequencer import acf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_fire,
	input  acf_status_t status,
	input  logic        res_busy,
	output ctl_t        ctl,
	output logic        step_en,
	output logic        item_ready,
	output logic        load_result
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	addr_t      pc_q;
	addr_t      next_pc;

	// Control word of the current step; the final step waits for a free result slot
	always_comb begin
		ctl         = ucode_rom(pc_q);
		step_en     = (state_q == S_RUN) && !(ctl.fin && res_busy);
		load_result = step_en && ctl.fin;
		item_ready  = (state_q == S_IDLE);
	end

	// Next step address, with the multi-way dispatch at the program head
	always_comb begin
		case (ctl.jump)
			J_DISPATCH: begin
				if (status.kind == KIND_BARO) begin
					next_pc = status.started ? ADDR_BARO : ADDR_INIT;
				end else if (status.started && !status.dt_zero) begin
					next_pc = ADDR_ACCEL;
				end else begin
					next_pc = ADDR_FIN;
				end
			end
			default: next_pc = ctl.next;
		endcase
	end

	// Step counter and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= ADDR_FIN;
		end else if (item_fire) begin
			state_q <= S_RUN;
			pc_q    <= ADDR_DISPATCH;
		end else if (step_en) begin
			if (ctl.fin) begin
				state_q <= S_IDLE;
				pc_q    <= ADDR_FIN;
			end else begin
				pc_q <= next_pc;
			end
		end
	end

	a_fire_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |=> (state_q == S_RUN) && (pc_q == ADDR_DISPATCH))
		else $error("accepted transaction did not start the program");

	a_fin_idles: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> (state_q == S_IDLE) && (pc_q == ADDR_FIN))
		else $error("sequencer did not return to idle after the final step");

endmodule

// ----- sv/acf_datapath.sv -----
// ---------------------------------------------------------------------------
// Altitude complementary filter datapath
// Shared multiplier, accumulator and filter state, driven by the control word.
// ---------------------------------------------------------------------------
module acf_datapath import acf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_fire,
	input  logic                        kind,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic        [DT_W-1:0]      step_time,
	input  logic        [ALPHA_W-1:0]   alpha,
	input  logic        [HZ_W-1:0]      baro_hz,
	input  ctl_t                        ctl,
	input  logic                        step_en,
	output acf_status_t                 status,
	output logic signed [SAMPLE_W-1:0]  altitude,
	output logic signed [SAMPLE_W-1:0]  vert_speed
);

	// Latched item
	logic                       kind_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic        [DT_W-1:0]     dt_q;

	// Filter state
	logic signed [SAMPLE_W-1:0] alt_q;
	logic signed [SAMPLE_W-1:0] rate_q;
	logic signed [SAMPLE_W-1:0] offset_q;
	logic signed [SAMPLE_W-1:0] last_q;
	logic                       started_q;

	// Working registers
	logic        [TEMP_W-1:0]   temp_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;

	logic        [ALPHA_W-1:0]  weight;
	logic signed [MA_W-1:0]     rel;
	logic signed [MA_W-1:0]     diff;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    acc_next;

	assign weight   = ALPHA_W'(17'd32768 - {1'b0, alpha});
	assign rel      = $signed({sample_q[SAMPLE_W-1], sample_q})
			- $signed({offset_q[SAMPLE_W-1], offset_q});
	assign diff     = $signed({sample_q[SAMPLE_W-1], sample_q})
			- $signed({last_q[SAMPLE_W-1], last_q});
	assign prod_ext = ACC_W'(prod_q);

	// Multiplier operand selection
	always_comb begin
		case (ctl.mul_a)
			MA_ALT:  mul_a = MA_W'(alt_q);
			MA_RATE: mul_a = MA_W'(rate_q);
			MA_REL:  mul_a = rel;
			MA_DIFF: mul_a = diff;
			MA_SMP:  mul_a = MA_W'(sample_q);
			MA_HZ:   mul_a = $signed({{(MA_W-HZ_W){1'b0}}, baro_hz});
			default: mul_a = '0;
		endcase
		case (ctl.mul_b)
			MB_ALPHA:  mul_b = $signed({{(MB_W-ALPHA_W){1'b0}}, alpha});
			MB_WEIGHT: mul_b = $signed({{(MB_W-ALPHA_W){1'b0}}, weight});
			MB_TEMP:   mul_b = $signed({1'b0, temp_q});
			MB_DT:     mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt_q});
			default:   mul_b = '0;
		endcase
	end

	// Accumulator update
	always_comb begin
		case (ctl.acc_op)
			ACC_PROD:   acc_next = prod_ext;
			ACC_ADD:    acc_next = acc_q + prod_ext;
			ACC_RATE16: acc_next = $signed({{(ACC_W-SAMPLE_W-16){rate_q[SAMPLE_W-1]}},
					rate_q, 16'd0}) + prod_ext;
			ACC_ALT16:  acc_next = $signed({{(ACC_W-SAMPLE_W-16){alt_q[SAMPLE_W-1]}},
					alt_q, 16'd0}) + prod_ext;
			default:    acc_next = acc_q;
		endcase
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (item_fire) begin
			kind_q   <= kind;
			sample_q <= sample;
			dt_q     <= step_time;
		end
	end

	// Product and accumulator registers
	always_ff @(posedge clk) begin
		if (step_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			acc_q  <= acc_next;
			if (ctl.wb == WB_TEMP) begin
				temp_q <= prod_q[TEMP_W-1:0];
			end
		end
	end

	// Offset and previous barometer sample
	always_ff @(posedge clk) begin
		if (step_en) begin
			case (ctl.wb)
				WB_INIT: begin
					offset_q <= sample_q;
					last_q   <= sample_q;
				end
				WB_RATE15: last_q <= sample_q;
				default: ;
			endcase
		end
	end

	// Estimates and start flag; blends drop 15 fraction bits, integrations 16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q     <= '0;
			rate_q    <= '0;
			started_q <= 1'b0;
		end else if (step_en) begin
			case (ctl.wb)
				WB_ALT15:  alt_q  <= sat32(acc_q >>> 15);
				WB_RATE15: rate_q <= sat32(acc_q >>> 15);
				WB_ALT16:  alt_q  <= sat32(acc_q >>> 16);
				WB_RATE16: rate_q <= sat32(acc_q >>> 16);
				WB_INIT: begin
					alt_q     <= '0;
					rate_q    <= '0;
					started_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign status.kind    = kind_q;
	assign status.started = started_q;
	assign status.dt_zero = (dt_q == '0);
	assign altitude       = alt_q;
	assign vert_speed     = rate_q;

	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("start flag cleared after the first barometer sample");

	a_init_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && (ctl.wb == WB_INIT)) |=> started_q && (alt_q == '0) && (rate_q == '0))
		else $error("first barometer sample did not zero the estimates");

endmodule

// ----- verif/altitude_complementary_filter_tb.sv -----
// ---------------------------------------------------------------------------
// Altitude complementary filter testbench
// Drives barometer and acceleration transactions into the filter, predicts
// the altitude and climb rate estimates in Q16.16, and compares every result
// transaction with the oldest prediction. A directed table comes first, then
// random phases under several register settings and handshake idling mixes.
// ---------------------------------------------------------------------------
module altitude_complementary_filter_tb;
	import acf_pkg::*;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE  = 310;
	localparam int NUM_PHASES       = 6;
	localparam int DRAIN_CYCLES     = 12;
	localparam int DIR_ROWS         = 19;

	typedef struct packed {
		logic signed [31:0] altitude;
		logic signed [31:0] vert_speed;
		logic               ready_res;
	} estimate_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] sample;
		logic [15:0] step_time;
		logic        typed_exp;
		estimate_t   exp_est;
	} stim_row_t;

	localparam estimate_t NO_ESTIMATE     = '{32'sd0, 32'sd0, 1'b0};
	localparam estimate_t STARTED_AT_ZERO = '{32'sd0, 32'sd0, 1'b1};

	logic clk = 1'b0;
	logic arst_n;

	acf_item_if   item();
	acf_result_if result();
	acf_cfg_if    cfg();

	altitude_complementary_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// Directed table: extremes, both kinds, and the special cases of the filter
	stim_row_t dir_rows [DIR_ROWS] = '{
		// Acceleration before the first barometer sample is ignored
		'{KIND_ACCEL, 32'h7fff_ffff, 16'hffff, 1'b1, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h8000_0000, 16'h0001, 1'b1, NO_ESTIMATE},
		// First barometer sample latches the offset and zeroes the estimates
		'{KIND_BARO,  32'h0064_0000, 16'hffff, 1'b1, STARTED_AT_ZERO},
		// Large relative altitude and difference, with products well beyond 32 bits
		'{KIND_BARO,  32'h7fff_ffff, 16'hffff, 1'b0, NO_ESTIMATE},
		// Zero interval: acceleration ignored
		'{KIND_ACCEL, 32'h7fff_ffff, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h7fff_ffff, 16'hffff, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h8000_0000, 16'hffff, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h8000_0000, 16'hffff, 1'b0, NO_ESTIMATE},
		'{KIND_BARO,  32'h8000_0000, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_BARO,  32'h0000_0000, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_BARO,  32'h0000_0000, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h0001_0000, 16'h0290, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'hffff_0000, 16'h8000, 1'b0, NO_ESTIMATE},
		'{KIND_BARO,  32'h0000_1234, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h1234_5678, 16'h0001, 1'b0, NO_ESTIMATE},
		// Small negative products must round towards minus infinity
		'{KIND_ACCEL, 32'hffff_fffe, 16'hffff, 1'b0, NO_ESTIMATE},
		'{KIND_BARO,  32'h7fff_ffff, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_BARO,  32'h7fff_ffff, 16'h0000, 1'b0, NO_ESTIMATE},
		'{KIND_ACCEL, 32'h0000_0000, 16'h5555, 1'b0, NO_ESTIMATE}
	};

	// Predicted filter state and register copies
	logic signed [31:0] est_alt;
	logic signed [31:0] est_rate;
	logic signed [31:0] gnd_offset;
	logic signed [31:0] prev_baro;
	logic               est_started;
	logic [15:0]        alpha_reg;
	logic [9:0]         baro_hz_reg;

	estimate_t pending_estimates [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_accepted = 0;
	int baro_count = 0;
	int accel_count = 0;
	int results_checked = 0;
	int failures = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int flight_alt = 100 * 65536;

	// Clamp a wide value to the signed 32-bit range
	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Weighted mix of a kept estimate and a barometric measurement, Q1.15 weight
	function automatic logic signed [31:0] blend_q15(input longint kept, input longint meas,
			input longint weight);
		longint acc;
		acc = weight * kept + (64'sd32768 - weight) * meas;
		return clamp32(acc >>> 15);
	endfunction

	// Advance the predicted filter by one sensor transaction
	task automatic advance_estimate(input logic kind, input logic signed [31:0] smp,
			input logic [15:0] dt, output estimate_t est);
		longint s;
		longint d;
		longint a;
		longint hz;
		longint rel;
		longint climb;
		s  = longint'(smp);
		d  = longint'(dt);
		hz = longint'(baro_hz_reg);
		if (kind == KIND_BARO) begin
			if (!est_started) begin
				gnd_offset  = smp;
				prev_baro   = smp;
				est_alt     = '0;
				est_rate    = '0;
				est_started = 1'b1;
			end else begin
				a        = longint'((alpha_reg > ONE_Q15) ? ONE_Q15 : alpha_reg);
				rel      = s - longint'(gnd_offset);
				climb    = (s - longint'(prev_baro)) * hz;
				est_alt  = blend_q15(longint'(est_alt), rel, a);
				est_rate = blend_q15(longint'(est_rate), climb, a);
				prev_baro = smp;
			end
		end else if (est_started && dt != '0) begin
			est_rate = clamp32(longint'(est_rate) + ((s * d) >>> 16));
			est_alt  = clamp32(longint'(est_alt) + ((longint'(est_rate) * d) >>> 16));
		end
		est = '{est_alt, est_rate, est_started};
	endtask

	// Offer one sensor transaction, idling first at random, and record its estimate
	task automatic send_transaction(input logic kind, input logic signed [31:0] smp,
			input logic [15:0] dt, input logic typed_exp, input estimate_t typed_est);
		estimate_t est;
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid     <= 1'b1;
		item.kind      <= kind;
		item.sample    <= smp;
		item.step_time <= dt;
		do @(posedge clk); while (item.ready !== 1'b1);
		advance_estimate(kind, smp, dt, est);
		pending_estimates.push_back(typed_exp ? typed_est : est);
		items_accepted <= items_accepted + 1;
		if (kind == KIND_BARO) begin
			baro_count++;
		end else begin
			accel_count++;
		end
	endtask

	// Mostly plausible flight data, with some ignored items and full-range noise
	task automatic send_random_transaction();
		int          pick;
		logic        kind;
		logic signed [31:0] smp;
		logic [15:0] dt;
		pick = $urandom_range(99);
		if (pick < 70) begin
			kind = ($urandom_range(99) < 40) ? KIND_BARO : KIND_ACCEL;
			flight_alt = flight_alt + int'($urandom_range(131072)) - 65536;
			if (flight_alt > 2000 * 65536) begin
				flight_alt = 2000 * 65536;
			end else if (flight_alt < -2000 * 65536) begin
				flight_alt = -2000 * 65536;
			end
			if (kind == KIND_BARO) begin
				smp = flight_alt + int'($urandom_range(65536)) - 32768;
			end else begin
				smp = int'($urandom_range(40 * 65536)) - 20 * 65536;
			end
			dt = 16'($urandom_range(1311, 1));
		end else if (pick < 75) begin
			kind = KIND_ACCEL;
			smp  = $urandom;
			dt   = '0;
		end else begin
			kind = 1'($urandom_range(1));
			smp  = $urandom;
			dt   = 16'($urandom);
		end
		send_transaction(kind, smp, dt, 1'b0, NO_ESTIMATE);
	endtask

	// One register write; the caller lowers valid after its last write
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		if (idx == REG_BLEND_WEIGHT) begin
			alpha_reg = value;
		end else begin
			baro_hz_reg = value[9:0];
		end
	endtask

	// Wait until every predicted result has arrived and the block has settled
	task automatic wait_drained();
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random back-pressure, one long hold-off, and the comparison
	always @(posedge clk or negedge arst_n) begin : result_side
		estimate_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				if (pending_estimates.size() == 0) begin
					$display("%0t: unexpected result, altitude %h climb rate %h ready %b",
						$time, result.altitude, result.vert_speed, result.ready_res);
					failures++;
				end else begin
					want = pending_estimates.pop_front();
					results_checked++;
					if (result.altitude !== want.altitude) begin
						$display("%0t: altitude mismatch, expected %h, actual %h",
							$time, want.altitude, result.altitude);
						failures++;
					end
					if (result.vert_speed !== want.vert_speed) begin
						$display("%0t: climb rate mismatch, expected %h, actual %h",
							$time, want.vert_speed, result.vert_speed);
						failures++;
					end
					if (result.ready_res !== want.ready_res) begin
						$display("%0t: ready flag mismatch, expected %b, actual %b",
							$time, want.ready_res, result.ready_res);
						failures++;
					end
				end
			end
			// The long hold-off lets the block fill up and stall its input
			if (hold_left != 0) begin
				result.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if (!hold_done && items_accepted == DIR_ROWS + 100) begin
				result.ready <= 1'b0;
				hold_left    <= LONG_HOLD_CYCLES;
				hold_done    <= 1'b1;
			end else begin
				result.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d results outstanding", $time,
				pending_estimates.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: directed table, then random phases under varying settings
	initial begin
		int          p;
		int          i;
		logic [15:0] weight_val;
		logic [15:0] hz_data;
		arst_n         = 1'b0;
		item.valid     = 1'b0;
		item.kind      = KIND_BARO;
		item.sample    = '0;
		item.step_time = '0;
		cfg.valid      = 1'b0;
		cfg.index      = REG_BLEND_WEIGHT;
		cfg.data       = '0;
		est_alt        = '0;
		est_rate       = '0;
		gnd_offset     = '0;
		prev_baro      = '0;
		est_started    = 1'b0;
		alpha_reg      = BLEND_RESET;
		baro_hz_reg    = BARO_HZ_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values, no idling
		for (i = 0; i < DIR_ROWS; i++) begin
			send_transaction(dir_rows[i].kind, dir_rows[i].sample, dir_rows[i].step_time,
				dir_rows[i].typed_exp, dir_rows[i].exp_est);
		end
		item.valid <= 1'b0;

		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin
					weight_val = 16'd0;
					hz_data    = 16'd1000;
				end
				1: begin
					// Weight above one and zero barometer rate
					weight_val = 16'hffff;
					hz_data    = 16'd0;
				end
				2: begin
					weight_val = ONE_Q15;
					hz_data    = 16'd1;
				end
				3: begin
					// Upper data bits beyond the rate register are dropped
					weight_val = 16'($urandom_range(32768));
					hz_data    = {6'($urandom_range(63)), 10'($urandom_range(1000, 1))};
				end
				4: begin
					weight_val = BLEND_RESET;
					hz_data    = 16'd1023;
				end
				default: begin
					weight_val = 16'($urandom_range(65535));
					hz_data    = 16'($urandom_range(1023));
				end
			endcase
			write_reg(REG_BLEND_WEIGHT, weight_val);
			write_reg(REG_BARO_RATE, hz_data);
			cfg.valid <= 1'b0;
			send_idle_pct = (p < 2) ? 16 : (p < 4) ? 55 : 0;
			recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 16 : 0;
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_random_transaction();
			end
			item.valid <= 1'b0;
		end

		wait_drained();
		$display("Covered %0d sensor transactions (%0d barometer, %0d acceleration) under %0d",
			baro_count + accel_count, baro_count, accel_count, NUM_PHASES + 1);
		$display("register settings; %0d results compared, %0d mismatches.",
			results_checked, failures);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- altitude_complementary_filter.f -----
sv/acf_pkg.sv
sv/acf_if.sv
sv/acf_sequencer.sv
sv/acf_datapath.sv
sv/altitude_complementary_filter.sv
verif/altitude_complementary_filter_tb.sv
